FILE: rtl/aerl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aerl_pkg: shared types and constants of the alarm event ring log
// item layouts on both channels, kind codes and default sizes
// ----------------------------------------------------------------------------
package aerl_pkg;

	// default sizes
	localparam int AERL_RING_DEPTH = 256;
	localparam int AERL_TIME_BITS  = 32;

	// kind codes carried in an event item
	localparam logic [2:0] KIND_START  = 3'd0;
	localparam logic [2:0] KIND_UPDATE = 3'd1;
	localparam logic [2:0] KIND_FINISH = 3'd2;
	localparam logic [2:0] KIND_SEND   = 3'd3;
	localparam logic [2:0] KIND_CLEAR  = 3'd4;

	typedef struct packed {
		logic [2:0]  kind;
		logic [31:0] now_time;
		logic [31:0] event_data;
	} evt_item_t;

	typedef struct packed {
		logic        status;
		logic [31:0] rec_start_time;
		logic [31:0] rec_end_time;
		logic [31:0] rec_payload;
		logic [7:0]  oldest_index;
		logic [7:0]  write_index;
		logic [7:0]  send_index;
	} rsp_item_t;

endpackage

FILE: rtl/alarm_event_ring_log.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alarm_event_ring_log: ring log of alarm records
// keeps start time, end time and payload of each alarm in a ring memory,
// managed by oldest, write and send pointers; hands out unsent records
// ----------------------------------------------------------------------------
//
//  channel | handshake            | payload    | direction
//  --------+----------------------+------------+----------
//  event   | evt_valid, evt_ready | evt        | into block
//  result  | rsp_valid, rsp_ready | rsp        | out of block
//
//  the accept cycle does the pointer and pending record update and issues
//  the memory write or read; the done state then loads the result register
//  from the registered memory read data once the result register is free
//  one result per item; a new item is taken while the last result still waits
//  reset clears pointers, the open flag and the pending record; the record
//  memory has no reset and needs no clearing pass
//  a stalled result holds the block after one further item is accepted
// ----------------------------------------------------------------------------
module alarm_event_ring_log
	import aerl_pkg::*;
#(
	parameter int RING_DEPTH = AERL_RING_DEPTH,
	parameter int TIME_BITS  = AERL_TIME_BITS
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      evt_valid,
	output logic      evt_ready,
	input  evt_item_t evt,
	output logic      rsp_valid,
	input  logic      rsp_ready,
	output rsp_item_t rsp
);

	localparam int PTR_W = $clog2(RING_DEPTH);
	localparam int REC_W = 2 * TIME_BITS + 32;
	localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(RING_DEPTH - 1);

	typedef enum logic {
		S_IDLE,
		S_DONE
	} state_t;

	// control and pointer state
	state_t               state_q;
	logic [PTR_W-1:0]     oldest_q;
	logic [PTR_W-1:0]     write_q;
	logic [PTR_W-1:0]     send_q;
	logic                 open_q;
	logic [TIME_BITS-1:0] pend_start_q;
	logic [TIME_BITS-1:0] pend_end_q;
	// per item result flags, taken at accept
	logic                 status_q;
	logic                 hit_q;
	logic                 rsp_valid_q;
	rsp_item_t            rsp_q;

	// next values computed in the accept cycle
	logic [PTR_W-1:0]     oldest_d;
	logic [PTR_W-1:0]     write_d;
	logic [PTR_W-1:0]     send_d;
	logic                 open_d;
	logic [TIME_BITS-1:0] pend_start_d;
	logic [TIME_BITS-1:0] pend_end_d;
	logic                 status_d;
	logic                 hit_d;

	logic                 accept;
	logic                 rsp_load;
	logic [TIME_BITS-1:0] now_t;
	logic [PTR_W-1:0]     write_nxt;
	logic [PTR_W-1:0]     oldest_nxt;
	logic [PTR_W-1:0]     send_fix;
	logic                 outside_win;

	// memory ports
	logic                 wr_en;
	logic [REC_W-1:0]     wr_data;
	logic                 rd_en;
	logic [REC_W-1:0]     rd_data;
	logic [TIME_BITS-1:0] rd_start;
	logic [TIME_BITS-1:0] rd_end;
	logic [31:0]          rd_pay;

	function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
		ring_next = (p == LAST_SLOT) ? '0 : p + PTR_W'(1);
	endfunction

	assign evt_ready = (state_q == S_IDLE);
	assign accept    = evt_valid && evt_ready;
	assign rsp_load  = (state_q == S_DONE) && (!rsp_valid_q || rsp_ready);
	assign now_t     = TIME_BITS'(evt.now_time);

	// write pointer advance, pushing the oldest pointer when the ring fills
	assign write_nxt  = ring_next(write_q);
	assign oldest_nxt = (write_nxt == oldest_q) ? ring_next(oldest_q) : oldest_q;

	// send pointer pulled back into the live window
	always_comb begin
		if (write_q > oldest_q) begin
			outside_win = (send_q > write_q) || (send_q < oldest_q);
		end else begin
			outside_win = (send_q > write_q) && (send_q < oldest_q);
		end
		send_fix = outside_win ? oldest_q : send_q;
	end

	always_comb begin
		oldest_d     = oldest_q;
		write_d      = write_q;
		send_d       = send_q;
		open_d       = open_q;
		pend_start_d = pend_start_q;
		pend_end_d   = pend_end_q;
		status_d     = 1'b0;
		hit_d        = 1'b0;
		wr_en        = 1'b0;
		rd_en        = 1'b0;
		wr_data      = {pend_start_q, pend_end_q, evt.event_data};
		case (evt.kind)
			KIND_START: begin
				// a still-open record keeps its slot
				if (open_q) begin
					write_d  = write_nxt;
					oldest_d = oldest_nxt;
				end
				open_d       = 1'b1;
				pend_start_d = now_t;
				pend_end_d   = now_t;
			end
			KIND_UPDATE: begin
				wr_en      = accept;
				pend_end_d = now_t;
			end
			KIND_FINISH: begin
				wr_en      = accept;
				wr_data    = {pend_start_q, now_t, evt.event_data};
				pend_end_d = now_t;
				write_d    = write_nxt;
				oldest_d   = oldest_nxt;
				open_d     = 1'b0;
			end
			KIND_SEND: begin
				if (write_q == oldest_q) begin
					// empty ring
					status_d = 1'b1;
				end else begin
					send_d = send_fix;
					if (send_fix == write_q) begin
						// everything already sent
						status_d = 1'b1;
					end else begin
						rd_en  = accept;
						hit_d  = 1'b1;
						send_d = ring_next(send_fix);
					end
				end
			end
			KIND_CLEAR: begin
				oldest_d = '0;
				write_d  = '0;
				send_d   = '0;
			end
			default: begin
			end
		endcase
	end

	aerl_ram #(
		.WIDTH(REC_W),
		.DEPTH(RING_DEPTH)
	) u_rec_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (write_q),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (send_fix),
		.rd_data (rd_data)
	);

	assign rd_start = rd_data[REC_W-1 -: TIME_BITS];
	assign rd_end   = rd_data[32 +: TIME_BITS];
	assign rd_pay   = rd_data[31:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			oldest_q     <= '0;
			write_q      <= '0;
			send_q       <= '0;
			open_q       <= 1'b0;
			pend_start_q <= '0;
			pend_end_q   <= '0;
			status_q     <= 1'b0;
			hit_q        <= 1'b0;
			rsp_valid_q  <= 1'b0;
			rsp_q        <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						oldest_q     <= oldest_d;
						write_q      <= write_d;
						send_q       <= send_d;
						open_q       <= open_d;
						pend_start_q <= pend_start_d;
						pend_end_q   <= pend_end_d;
						status_q     <= status_d;
						hit_q        <= hit_d;
						state_q      <= S_DONE;
					end
				end
				S_DONE: begin
					if (rsp_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			// result register, freed by the consumer
			if (rsp_load) begin
				rsp_valid_q          <= 1'b1;
				rsp_q.status         <= status_q;
				rsp_q.rec_start_time <= hit_q ? 32'(rd_start) : '0;
				rsp_q.rec_end_time   <= hit_q ? 32'(rd_end) : '0;
				rsp_q.rec_payload    <= hit_q ? rd_pay : '0;
				rsp_q.oldest_index   <= 8'(oldest_q);
				rsp_q.write_index    <= 8'(write_q);
				rsp_q.send_index     <= 8'(send_q);
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`ifndef ASSERT_OFF
	// an accepted item always moves to the result cycle and blocks new items
	a_accept_done: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == S_DONE) && !evt_ready)
		else $error("accepted item did not reach result cycle");

	// the record memory is never written and read for the same item
	a_ram_port: assert property (@(posedge clk) disable iff (!arst_n)
		!(wr_en && rd_en))
		else $error("record memory written and read together");

	// a new result only appears after a result cycle
	a_rsp_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == S_DONE))
		else $error("result shown without a finished item");

	// an empty answer carries no record
	a_empty_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && rsp_q.status) |->
			(rsp_q.rec_start_time == '0) && (rsp_q.rec_end_time == '0) &&
			(rsp_q.rec_payload == '0))
		else $error("empty answer carries record data");
`endif

endmodule

FILE: rtl/aerl_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aerl_ram: simple dual port memory
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module aerl_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		// read data holds until the next read
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

FILE: tb/alarm_event_ring_log_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alarm_event_ring_log_tb: self-checking bench for the alarm event ring log
// drives start, update, finish, send, clear and spare kinds through the event
// channel and checks every result against an in-bench model of the ring,
// with random idling on both sides, a long result stall and a ring wrap
// ----------------------------------------------------------------------------
module alarm_event_ring_log_tb
	import aerl_pkg::*;
();

	// kinds the block ignores
	localparam logic [2:0] KIND_SPARE_5 = 3'd5;
	localparam logic [2:0] KIND_SPARE_6 = 3'd6;
	localparam logic [2:0] KIND_SPARE_7 = 3'd7;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int HOLD_CYCLES    = 80;
	localparam int DRAIN_CYCLES   = 4;

	logic      clk;
	logic      arst_n;
	logic      evt_valid;
	logic      evt_ready;
	evt_item_t evt;
	logic      rsp_valid;
	logic      rsp_ready;
	rsp_item_t rsp;

	// model of the ring: pointers, open flag, pending record, record memory
	int          log_oldest;
	int          log_write;
	int          log_send;
	bit          log_open;
	logic [31:0] log_pend_start;
	logic [31:0] log_pend_end;
	logic [31:0] log_start_mem [AERL_RING_DEPTH];
	logic [31:0] log_end_mem   [AERL_RING_DEPTH];
	logic [31:0] log_pay_mem   [AERL_RING_DEPTH];
	bit          log_slot_written [AERL_RING_DEPTH];

	rsp_item_t awaited_rsp_q [$];
	int        mismatch_count;
	int        items_sent;
	bit        calm_tail;   // no idling on either side
	bit        hold_rsp;    // ask the receiver for one long stall

	wire evt_fire = evt_valid && evt_ready;
	wire rsp_fire = rsp_valid && rsp_ready;

	alarm_event_ring_log dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.evt_valid (evt_valid),
		.evt_ready (evt_ready),
		.evt       (evt),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// ring model
	// ------------------------------------------------------------------

	function automatic int ring_next(int p);
		return (p + 1 >= AERL_RING_DEPTH) ? 0 : p + 1;
	endfunction

	// write pointer steps on and pushes the oldest pointer when the ring is full
	function automatic void advance_write();
		log_write = ring_next(log_write);
		if (log_write == log_oldest)
			log_oldest = ring_next(log_oldest);
	endfunction

	function automatic void store_pending(logic [31:0] pay);
		log_start_mem[log_write]    = log_pend_start;
		log_end_mem[log_write]      = log_pend_end;
		log_pay_mem[log_write]      = pay;
		log_slot_written[log_write] = 1'b1;
	endfunction

	// send pointer pulled back into the live window, only valid on a non-empty ring
	function automatic int window_cursor();
		int s;
		s = log_send;
		if (log_write > log_oldest) begin
			if (s > log_write || s < log_oldest)
				s = log_oldest;
		end else if (s > log_write && s < log_oldest) begin
			s = log_oldest;
		end
		return s;
	endfunction

	// a send that would hand out a slot skipped and never written
	function automatic bit send_hits_blank_slot();
		int s;
		if (log_write == log_oldest)
			return 1'b0;
		s = window_cursor();
		return (s != log_write) && !log_slot_written[s];
	endfunction

	// applies one event item to the ring and returns the result it causes
	function automatic rsp_item_t apply_log_item(evt_item_t it);
		rsp_item_t r;
		r = '0;
		case (it.kind)
			KIND_START: begin
				// a still-open record keeps its slot
				if (log_open)
					advance_write();
				log_open       = 1'b1;
				log_pend_start = it.now_time;
				log_pend_end   = it.now_time;
			end
			KIND_UPDATE: begin
				store_pending(it.event_data);
				log_pend_end = it.now_time;
			end
			KIND_FINISH: begin
				log_pend_end = it.now_time;
				store_pending(it.event_data);
				advance_write();
				log_open = 1'b0;
			end
			KIND_SEND: begin
				if (log_write == log_oldest) begin
					r.status = 1'b1;
				end else begin
					log_send = window_cursor();
					if (log_send == log_write) begin
						r.status = 1'b1;
					end else begin
						r.rec_start_time = log_start_mem[log_send];
						r.rec_end_time   = log_end_mem[log_send];
						r.rec_payload    = log_pay_mem[log_send];
						log_send         = ring_next(log_send);
					end
				end
			end
			KIND_CLEAR: begin
				// pointers only, the open record survives
				log_oldest = 0;
				log_write  = 0;
				log_send   = 0;
			end
			default: begin
			end
		endcase
		r.oldest_index = 8'(log_oldest);
		r.write_index  = 8'(log_write);
		r.send_index   = 8'(log_send);
		return r;
	endfunction

	// ------------------------------------------------------------------
	// event side
	// ------------------------------------------------------------------

	// offers one item, holds it until taken, then books its result
	task automatic push_item(input logic [2:0] kind, input logic [31:0] now,
			input logic [31:0] data);
		evt_item_t it;
		int        gap;
		it.kind       = kind;
		it.now_time   = now;
		it.event_data = data;
		@(negedge clk);
		if (!calm_tail && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 4);
			evt_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		evt_valid <= 1'b1;
		evt       <= it;
		@(posedge clk);
		while (!evt_ready) @(posedge clk);
		awaited_rsp_q.push_back(apply_log_item(it));
		items_sent++;
	endtask

	// a send that could reach a never written slot goes out as a spare kind
	task automatic push_send();
		if (send_hits_blank_slot())
			push_item(KIND_SPARE_5 + 3'($urandom_range(0, 2)), $urandom, $urandom);
		else
			push_item(KIND_SEND, $urandom, $urandom);
	endtask

	// start, zero to three updates, finish, all with random content
	task automatic push_alarm();
		int n;
		n = $urandom_range(0, 3);
		push_item(KIND_START, $urandom, $urandom);
		repeat (n) push_item(KIND_UPDATE, $urandom, $urandom);
		push_item(KIND_FINISH, $urandom, $urandom);
	endtask

	// ------------------------------------------------------------------
	// result side
	// ------------------------------------------------------------------

	// random stall bursts, or one long hold-off on request
	initial begin
		rsp_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_rsp) begin
				rsp_ready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
				hold_rsp = 1'b0;
			end else if (!calm_tail && $urandom_range(0, 4) == 0) begin
				rsp_ready <= 1'b0;
				repeat ($urandom_range(0, 3)) @(negedge clk);
			end else begin
				rsp_ready <= 1'b1;
			end
		end
	end

	// every result is matched against the oldest booked one
	always @(posedge clk) begin
		rsp_item_t want;
		if (arst_n && rsp_fire) begin
			if (awaited_rsp_q.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("%0t: result with nothing booked: %h", $realtime, rsp);
			end else begin
				want = awaited_rsp_q.pop_front();
				if (rsp.status !== want.status ||
						rsp.rec_start_time !== want.rec_start_time ||
						rsp.rec_end_time !== want.rec_end_time ||
						rsp.rec_payload !== want.rec_payload ||
						rsp.oldest_index !== want.oldest_index ||
						rsp.write_index !== want.write_index ||
						rsp.send_index !== want.send_index) begin
					mismatch_count++;
					if (mismatch_count <= 10) begin
						$display("%0t: mismatch status %b/%b start %h/%h end %h/%h",
							$realtime, want.status, rsp.status, want.rec_start_time,
							rsp.rec_start_time, want.rec_end_time, rsp.rec_end_time);
						$display("    payload %h/%h oldest %0d/%0d write %0d/%0d send %0d/%0d",
							want.rec_payload, rsp.rec_payload, want.oldest_index,
							rsp.oldest_index, want.write_index, rsp.write_index,
							want.send_index, rsp.send_index);
					end
				end
			end
		end
	end

	// ends the run once nothing has moved on either channel for too long
	initial begin
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if (evt_fire || rsp_fire)
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("*** FAILED ***");
		$finish;
	end

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------

	// a send on an empty ring and the ignored kinds, two of them at field extremes
	task automatic test_idle_kinds();
		push_item(KIND_SEND, 32'h0, 32'h0);
		push_item(KIND_SPARE_5, 32'h0, 32'h0);
		push_item(KIND_SPARE_6, 32'hffff_ffff, 32'hffff_ffff);
		push_item(KIND_SPARE_7, $urandom, $urandom);
	endtask

	// one full alarm with extreme stamps, read back, then nothing left
	task automatic test_alarm_cycle();
		push_item(KIND_START, 32'h0, 32'h0);
		push_item(KIND_UPDATE, 32'h0, 32'h0);
		push_item(KIND_UPDATE, 32'hffff_ffff, 32'hffff_ffff);
		push_item(KIND_FINISH, 32'hffff_ffff, 32'hffff_ffff);
		push_item(KIND_SEND, 32'h0, 32'h0);
		push_item(KIND_SEND, 32'h0, 32'h0);
	endtask

	// a start while a record is open moves past the open record's slot
	task automatic test_open_restart();
		push_item(KIND_START, 32'h0000_1000, $urandom);
		push_item(KIND_UPDATE, 32'h0000_1010, 32'ha5a5_5a5a);
		push_item(KIND_START, 32'h0000_2000, $urandom);
		push_item(KIND_FINISH, 32'h0000_2020, 32'h5a5a_a5a5);
		push_item(KIND_SEND, $urandom, $urandom);
		push_item(KIND_SEND, $urandom, $urandom);
		push_item(KIND_SEND, $urandom, $urandom);
	endtask

	// clear empties the window, memory stays
	task automatic test_clear();
		push_item(KIND_CLEAR, $urandom, $urandom);
		push_item(KIND_SEND, $urandom, $urandom);
		push_item(KIND_START, $urandom, $urandom);
		push_item(KIND_FINISH, $urandom, $urandom);
		push_item(KIND_SEND, $urandom, $urandom);
	endtask

	// receiver stalls long while items keep coming, the block must back up
	task automatic test_backpressure();
		hold_rsp = 1'b1;
		repeat (3) push_alarm();
		repeat (4) push_send();
	endtask

	// more records than slots: oldest pointer gets pushed, sends are pulled back
	task automatic test_ring_wrap();
		int i;
		for (i = 0; i < AERL_RING_DEPTH + 20; i++) begin
			push_item(KIND_FINISH, $urandom, $urandom);
			if (i % 40 == 7)
				push_send();
		end
		repeat (6) push_send();
	endtask

	// mostly well-formed alarms and sends, some clears and stray items
	task automatic test_random_traffic(input int n_items);
		int target;
		int pick;
		target = items_sent + n_items;
		while (items_sent < target) begin
			pick = $urandom_range(0, 99);
			if (pick < 55) begin
				push_alarm();
			end else if (pick < 82) begin
				repeat ($urandom_range(1, 3)) push_send();
			end else if (pick < 84) begin
				push_item(KIND_CLEAR, $urandom, $urandom);
			end else begin
				case ($urandom_range(0, 3))
					0: push_item(KIND_UPDATE, $urandom, $urandom);
					1: push_item(KIND_FINISH, $urandom, $urandom);
					2: push_item(KIND_START, $urandom, $urandom);
					default: push_item(KIND_SPARE_5 + 3'($urandom_range(0, 2)),
						$urandom, $urandom);
				endcase
			end
		end
	endtask

	initial begin
		int i;
		evt_valid      = 1'b0;
		evt            = '0;
		arst_n         = 1'b0;
		mismatch_count = 0;
		items_sent     = 0;
		calm_tail      = 1'b0;
		hold_rsp       = 1'b0;
		log_oldest     = 0;
		log_write      = 0;
		log_send       = 0;
		log_open       = 1'b0;
		log_pend_start = '0;
		log_pend_end   = '0;
		for (i = 0; i < AERL_RING_DEPTH; i++) begin
			log_start_mem[i]    = '0;
			log_end_mem[i]      = '0;
			log_pay_mem[i]      = '0;
			log_slot_written[i] = 1'b0;
		end

		// single reset at the start
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_idle_kinds();
		test_alarm_cycle();
		test_open_restart();
		test_clear();
		test_backpressure();
		test_ring_wrap();
		test_random_traffic(600);

		// last stretch runs with no random idling on either side
		calm_tail = 1'b1;
		test_random_traffic(120);

		@(negedge clk);
		evt_valid <= 1'b0;
		while (awaited_rsp_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && awaited_rsp_q.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
